// ===== sv/c2d_pkg.sv =====
// shared constants, types and register codes for the square 2d convolution unit
// no dependencies; every other file but c2d_fifo refers to it by scoped names
package c2d_pkg;

    // default geometry limits
    localparam int MAX_KERNEL_DEF = 5;
    localparam int MAX_IMAGE_DEF  = 256;

    // fixed field widths
    localparam int DATA_W      = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 38;
    localparam int IMG_REG_W   = 9;
    localparam int KER_REG_W   = 3;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // queue depths
    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

    // register indexes
    localparam logic REG_IMAGE_SIZE  = 1'b0;
    localparam logic REG_KERNEL_SIZE = 1'b1;

    // reset values of the registers
    localparam logic [IMG_REG_W-1:0] IMAGE_SIZE_RST  = 9'd256;
    localparam logic [KER_REG_W-1:0] KERNEL_SIZE_RST = 3'd3;

    // control flags of one queue entry
    typedef struct packed {
        logic is_kernel;
        logic emit;
        logic row_end;
        logic last;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

endpackage

// ===== sv/c2d_fifo.sv =====
// small synchronous fifo with occupancy count, used between front and back and for results
// depends on nothing but its parameters
module c2d_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_data,
    input  logic                         i_pop,
    output logic [W-1:0]                 o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;

    // pointer and count update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

    // no beat pushed into a full fifo
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_cnt == CW'(DEPTH)))
        else $error("fifo overflow");

    // no beat popped from an empty fifo
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_cnt == '0))
        else $error("fifo underflow");

    // count tracks pushes and pops
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("fifo count mismatch");

endmodule

// ===== sv/c2d_front.sv =====
// front part: accepts items, tracks kernel and pixel positions, keeps the line buffer
// depends on c2d_pkg; feeds the work queue read by c2d_back
module c2d_front #(
    parameter int MAX_KERNEL = c2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_IMAGE  = c2d_pkg::MAX_IMAGE_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_clr,
    input  logic [$clog2(MAX_IMAGE+1)-1:0]                i_n,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]               i_k,
    input  logic                                          i_push,
    input  logic                                          i_mode,
    input  logic signed [c2d_pkg::DATA_W-1:0]             i_value,
    output logic                                          o_full,
    input  logic [$clog2(c2d_pkg::QUEUE_DEPTH+1)-1:0]     i_q_cnt,
    output logic                                          o_q_push,
    output c2d_pkg::t_ctl                                 o_q_ctl,
    output logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] o_q_ka,
    output logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] o_q_kb,
    output logic [MAX_KERNEL*c2d_pkg::DATA_W-1:0]         o_q_col
);

    localparam int DW  = c2d_pkg::DATA_W;
    localparam int NW  = $clog2(MAX_IMAGE+1);
    localparam int KNW = $clog2(MAX_KERNEL+1);
    localparam int CW  = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;
    localparam int KIW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int EW  = ((NW > KNW) ? NW : KNW) + 1;
    localparam int QCW = $clog2(c2d_pkg::QUEUE_DEPTH+1);
    localparam int LBE = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;

    logic [CW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [KIW-1:0]     r_ka;
    logic [KIW-1:0]     r_kb;
    logic               r_a_vld;
    c2d_pkg::t_ctl      r_a_ctl;
    logic [DW-1:0]      r_a_val;
    logic [CW-1:0]      r_a_addr;
    logic [KIW-1:0]     r_a_ka;
    logic [KIW-1:0]     r_a_kb;
    logic [LBE*DW-1:0]  r_rd;
    logic [LBE*DW-1:0]  r_line [MAX_IMAGE];
    logic [LBE*DW-1:0]  n_word;
    logic               acc;
    logic               col_end;
    logic               row_last;
    logic               kb_end;
    logic               ka_end;
    logic               emit;

    // space check counts the queue and the beat in flight
    assign o_full = ((QCW+1)'(i_q_cnt) + (QCW+1)'(r_a_vld))
                    >= (QCW+1)'(c2d_pkg::QUEUE_DEPTH);
    assign acc    = i_push && !o_full;

    // position flags
    assign col_end  = EW'(r_col) == EW'(i_n) - EW'(1);
    assign row_last = EW'(r_row) == EW'(i_n) - EW'(1);
    assign kb_end   = EW'(r_kb) == EW'(i_k) - EW'(1);
    assign ka_end   = EW'(r_ka) == EW'(i_k) - EW'(1);
    assign emit     = (EW'(r_row) + EW'(1) >= EW'(i_k)) && (EW'(r_col) + EW'(1) >= EW'(i_k));

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_ka    <= '0;
            r_kb    <= '0;
        end else begin
            r_a_vld <= acc;
            if (i_clr) begin
                r_row <= '0;
                r_col <= '0;
                r_ka  <= '0;
                r_kb  <= '0;
            end else if (acc) begin
                if (!i_mode) begin
                    if (kb_end) begin
                        r_kb <= '0;
                        r_ka <= ka_end ? '0 : r_ka + KIW'(1);
                    end else begin
                        r_kb <= r_kb + KIW'(1);
                    end
                end else begin
                    if (col_end) begin
                        r_col <= '0;
                        r_row <= row_last ? '0 : r_row + CW'(1);
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
            end
        end
    end

    // stage payload and line buffer read
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_ctl.is_kernel <= !i_mode;
            r_a_ctl.emit      <= i_mode && emit;
            r_a_ctl.row_end   <= col_end;
            r_a_ctl.last      <= col_end && row_last;
            r_a_val           <= i_value;
            r_a_addr          <= r_col;
            r_a_ka            <= r_ka;
            r_a_kb            <= r_kb;
            if (i_mode) begin
                r_rd <= r_line[r_col];
            end
        end
    end

    // line buffer write back, newest row first
    always_ff @(posedge i_clk) begin
        if (r_a_vld && !r_a_ctl.is_kernel) begin
            r_line[r_a_addr] <= n_word;
        end
    end

    // column assembly and shifted line word
    for (genvar j = 0; j < LBE; j++) begin : g_word
        if (j == 0) begin : g_new
            assign n_word[DW-1:0] = r_a_val;
        end else begin : g_old
            assign n_word[j*DW +: DW] = r_rd[(j-1)*DW +: DW];
        end
    end

    for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_col
        if (a == 0) begin : g_new
            assign o_q_col[DW-1:0] = r_a_val;
        end else begin : g_old
            assign o_q_col[a*DW +: DW] = r_rd[(a-1)*DW +: DW];
        end
    end

    assign o_q_push = r_a_vld;
    assign o_q_ctl  = r_a_ctl;
    assign o_q_ka   = r_a_ka;
    assign o_q_kb   = r_a_kb;

endmodule

// ===== sv/c2d_back.sv =====
// back part: applies kernel writes, shifts the window, multiply-accumulate tree
// depends on c2d_pkg; reads the work queue and writes the result fifo
module c2d_back #(
    parameter int MAX_KERNEL = c2d_pkg::MAX_KERNEL_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic [$clog2(MAX_KERNEL+1)-1:0]               i_k,
    input  logic                                          i_q_empty,
    output logic                                          o_q_pop,
    input  c2d_pkg::t_ctl                                 i_q_ctl,
    input  logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] i_q_ka,
    input  logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] i_q_kb,
    input  logic [MAX_KERNEL*c2d_pkg::DATA_W-1:0]         i_q_col,
    input  logic [$clog2(c2d_pkg::OUT_DEPTH+1)-1:0]       i_o_cnt,
    output logic                                          o_o_push,
    output logic signed [c2d_pkg::SUM_W-1:0]              o_o_sum,
    output logic                                          o_o_row_end,
    output logic                                          o_o_last
);

    localparam int DW  = c2d_pkg::DATA_W;
    localparam int PW  = c2d_pkg::PROD_W;
    localparam int SW  = c2d_pkg::SUM_W;
    localparam int KNW = $clog2(MAX_KERNEL+1);
    localparam int KLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL*MAX_KERNEL) : 1;
    localparam int OCW = $clog2(c2d_pkg::OUT_DEPTH+1);

    logic signed [DW-1:0] r_win  [MAX_KERNEL][MAX_KERNEL];
    logic signed [DW-1:0] r_ker  [MAX_KERNEL*MAX_KERNEL];
    logic signed [DW-1:0] n_win  [MAX_KERNEL][MAX_KERNEL];
    logic signed [PW-1:0] r_prod [MAX_KERNEL][MAX_KERNEL];
    logic signed [SW-1:0] r_rsum [MAX_KERNEL];
    logic signed [SW-1:0] n_rsum [MAX_KERNEL];
    logic signed [SW-1:0] n_total;
    logic [KLW-1:0]       ker_wr_idx;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_re1;
    logic                 r_la1;
    logic                 r_re2;
    logic                 r_la2;
    logic                 do_mac;

    // pop only with room for everything in flight
    assign o_q_pop = !i_q_empty &&
        ((OCW+2)'(i_o_cnt) + (OCW+2)'(r_v1) + (OCW+2)'(r_v2)
         < (OCW+2)'(c2d_pkg::OUT_DEPTH));
    assign do_mac  = o_q_pop && !i_q_ctl.is_kernel && i_q_ctl.emit;

    // coefficients kept in row-major order of the current kernel size
    assign ker_wr_idx = KLW'(i_q_ka) * KLW'(i_k) + KLW'(i_q_kb);

    // window after shifting in the new column
    for (genvar a = 0; a < MAX_KERNEL; a++) begin : g_wa
        for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_wb
            if (b == 0) begin : g_in
                assign n_win[a][b] = i_q_col[a*DW +: DW];
            end else begin : g_sh
                assign n_win[a][b] = r_win[a][b-1];
            end
        end
    end

    // valid flags of the tree
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= do_mac;
            r_v2 <= r_v1;
        end
    end

    // kernel store, window and products
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_ctl.is_kernel) begin
            r_ker[ker_wr_idx] <= i_q_col[DW-1:0];
        end
        if (o_q_pop && !i_q_ctl.is_kernel) begin
            r_win <= n_win;
        end
        if (do_mac) begin
            for (int a = 0; a < MAX_KERNEL; a++) begin
                for (int b = 0; b < MAX_KERNEL; b++) begin
                    if (KNW'(a) < i_k && KNW'(b) < i_k) begin
                        r_prod[a][b] <= n_win[a][b]
                                        * r_ker[KLW'(a) * KLW'(i_k) + KLW'(b)];
                    end else begin
                        r_prod[a][b] <= '0;
                    end
                end
            end
            r_re1 <= i_q_ctl.row_end;
            r_la1 <= i_q_ctl.last;
        end
        if (r_v1) begin
            r_rsum <= n_rsum;
            r_re2  <= r_re1;
            r_la2  <= r_la1;
        end
    end

    // row sums of the products
    always_comb begin
        for (int a = 0; a < MAX_KERNEL; a++) begin
            n_rsum[a] = '0;
            for (int b = 0; b < MAX_KERNEL; b++) begin
                n_rsum[a] = n_rsum[a] + SW'(r_prod[a][b]);
            end
        end
    end

    // final sum of the row sums
    always_comb begin
        n_total = '0;
        for (int a = 0; a < MAX_KERNEL; a++) begin
            n_total = n_total + r_rsum[a];
        end
    end

    assign o_o_push    = r_v2;
    assign o_o_sum     = n_total;
    assign o_o_row_end = r_re2;
    assign o_o_last    = r_la2;

endmodule

// ===== sv/conv2d_valid_square_unit.sv =====
// a pixel beat passes the front stage register, the work queue, the product and row-sum registers
// into a four-entry result fifo; one item per cycle, kernel or pixel, is taken while full is low
// the multiply array handles a full window at once; push is held off only when the work queue is full
// reset (synchronous, active low) sets image size 256, kernel size 3 and clears all positions;
// line buffer and kernel store hold unknown data until written
module conv2d_valid_square_unit #(
    parameter int MAX_KERNEL = c2d_pkg::MAX_KERNEL_DEF,
    parameter int MAX_IMAGE  = c2d_pkg::MAX_IMAGE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // item channel
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  i_mode,
    input  logic signed [c2d_pkg::DATA_W-1:0]     i_value,
    // result channel
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [c2d_pkg::SUM_W-1:0]      o_conv_sum,
    output logic                                  o_row_end,
    output logic                                  o_last,
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [c2d_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [c2d_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [c2d_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam int NW  = $clog2(MAX_IMAGE+1);
    localparam int KNW = $clog2(MAX_KERNEL+1);
    localparam int KIW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int QW  = c2d_pkg::CTL_W + 2*KIW + MAX_KERNEL*c2d_pkg::DATA_W;
    localparam int OW  = c2d_pkg::SUM_W + 2;
    localparam int QCW = $clog2(c2d_pkg::QUEUE_DEPTH+1);
    localparam int OCW = $clog2(c2d_pkg::OUT_DEPTH+1);

    logic [c2d_pkg::IMG_REG_W-1:0] r_image_size;
    logic [c2d_pkg::KER_REG_W-1:0] r_kernel_size;
    logic                          cfg_wr;
    logic [NW-1:0]                 eff_n;
    logic [KNW-1:0]                eff_k;
    int                            n_int;
    int                            k_int;

    logic                          f_push;
    c2d_pkg::t_ctl                 f_ctl;
    logic [KIW-1:0]                f_ka;
    logic [KIW-1:0]                f_kb;
    logic [MAX_KERNEL*c2d_pkg::DATA_W-1:0] f_col;
    logic [QW-1:0]                 q_out;
    logic                          q_empty;
    logic                          q_pop;
    logic [QCW-1:0]                q_cnt;
    c2d_pkg::t_ctl                 b_ctl;
    logic [KIW-1:0]                b_ka;
    logic [KIW-1:0]                b_kb;
    logic [MAX_KERNEL*c2d_pkg::DATA_W-1:0] b_col;

    logic                          o_push;
    logic signed [c2d_pkg::SUM_W-1:0] o_sum;
    logic                          o_re;
    logic                          o_la;
    logic [OW-1:0]                 of_out;
    logic [OCW-1:0]                of_cnt;

    // register write and read
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size  <= c2d_pkg::IMAGE_SIZE_RST;
            r_kernel_size <= c2d_pkg::KERNEL_SIZE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                c2d_pkg::REG_IMAGE_SIZE:  r_image_size  <= pwdata[c2d_pkg::IMG_REG_W-1:0];
                c2d_pkg::REG_KERNEL_SIZE: r_kernel_size <= pwdata[c2d_pkg::KER_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            c2d_pkg::REG_IMAGE_SIZE:  prdata = c2d_pkg::APB_DATA_W'(r_image_size);
            c2d_pkg::REG_KERNEL_SIZE: prdata = c2d_pkg::APB_DATA_W'(r_kernel_size);
            default:                  prdata = '0;
        endcase
    end

    // effective sizes after saturation
    always_comb begin
        n_int = int'(r_image_size);
        if (n_int < 1) n_int = 1;
        if (n_int > MAX_IMAGE) n_int = MAX_IMAGE;
        k_int = int'(r_kernel_size);
        if (k_int < 1) k_int = 1;
        if (k_int > MAX_KERNEL) k_int = MAX_KERNEL;
        if (k_int > n_int) k_int = n_int;
        eff_n = NW'(n_int);
        eff_k = KNW'(k_int);
    end

    // front part
    c2d_front #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_IMAGE  (MAX_IMAGE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (cfg_wr),
        .i_n      (eff_n),
        .i_k      (eff_k),
        .i_push   (push),
        .i_mode   (i_mode),
        .i_value  (i_value),
        .o_full   (full),
        .i_q_cnt  (q_cnt),
        .o_q_push (f_push),
        .o_q_ctl  (f_ctl),
        .o_q_ka   (f_ka),
        .o_q_kb   (f_kb),
        .o_q_col  (f_col)
    );

    // work queue between front and back
    c2d_fifo #(
        .W     (QW),
        .DEPTH (c2d_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_ctl, f_ka, f_kb, f_col}),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_count (q_cnt)
    );

    assign {b_ctl, b_ka, b_kb, b_col} = q_out;

    // back part
    c2d_back #(
        .MAX_KERNEL (MAX_KERNEL)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_k         (eff_k),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_q_ctl     (b_ctl),
        .i_q_ka      (b_ka),
        .i_q_kb      (b_kb),
        .i_q_col     (b_col),
        .i_o_cnt     (of_cnt),
        .o_o_push    (o_push),
        .o_o_sum     (o_sum),
        .o_o_row_end (o_re),
        .o_o_last    (o_la)
    );

    // result fifo
    c2d_fifo #(
        .W     (OW),
        .DEPTH (c2d_pkg::OUT_DEPTH)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_push),
        .i_data  ({o_sum, o_re, o_la}),
        .i_pop   (pop && !empty),
        .o_data  (of_out),
        .o_empty (empty),
        .o_count (of_cnt)
    );

    assign {o_conv_sum, o_row_end, o_last} = of_out;

endmodule

// ===== sim/tb_conv2d_valid_square_unit.sv =====
// testbench for conv2d_valid_square_unit: directed table, then random phases over several sizes
// depends on c2d_pkg and the unit; checks every result beat against an in-bench convolution model
module tb_conv2d_valid_square_unit;

    localparam int LIMIT_CYCLES = 600000;
    localparam int MAXK = c2d_pkg::MAX_KERNEL_DEF;
    localparam int MAXN = c2d_pkg::MAX_IMAGE_DEF;
    localparam logic MODE_KERNEL = 1'b0;
    localparam logic MODE_PIXEL  = 1'b1;

    typedef struct {
        logic signed [c2d_pkg::SUM_W-1:0] sum;
        logic                             row_end;
        logic                             last;
    } t_conv_out;

    typedef struct {
        logic                              mode;
        logic signed [c2d_pkg::DATA_W-1:0] value;
        bit                                fixed;
        t_conv_out                         res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0, pop = 1'b0;
    logic full, empty;
    logic i_mode = 1'b0;
    logic signed [c2d_pkg::DATA_W-1:0] i_value = '0;
    logic signed [c2d_pkg::SUM_W-1:0] o_conv_sum;
    logic o_row_end, o_last;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [c2d_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [c2d_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [c2d_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    conv2d_valid_square_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // convolution model state
    logic [c2d_pkg::IMG_REG_W-1:0]     img_reg;
    logic [c2d_pkg::KER_REG_W-1:0]     ker_reg;
    logic signed [c2d_pkg::DATA_W-1:0] rows_mem [MAXK][MAXN];
    logic signed [c2d_pkg::DATA_W-1:0] coef_mem [MAXK*MAXK];
    int unsigned coef_idx, pos_row, pos_col;

    t_conv_out pending_sums[$];
    int errors = 0;
    int n_results = 0;
    int n_items = 0;
    int cycles = 0;
    bit send_idle = 1'b1, recv_idle = 1'b1;

    function automatic int unsigned side_n();
        int unsigned n = img_reg;
        if (n < 1) n = 1;
        if (n > MAXN) n = MAXN;
        return n;
    endfunction

    function automatic int unsigned side_k();
        int unsigned k = ker_reg;
        if (k < 1) k = 1;
        if (k > MAXK) k = MAXK;
        if (k > side_n()) k = side_n();
        return k;
    endfunction

    // advance the model by one accepted beat; returns 1 when a sum is due
    function automatic bit conv_advance(input logic mode,
                                        input logic signed [c2d_pkg::DATA_W-1:0] v,
                                        output t_conv_out res);
        int unsigned n = side_n();
        int unsigned k = side_k();
        int unsigned r = pos_row, c = pos_col, slot;
        longint acc = 0;
        bit due = 1'b0;
        res = '{default: '0};
        if (mode == MODE_KERNEL) begin
            if (coef_idx >= k*k) coef_idx = 0;
            coef_mem[coef_idx] = v;
            coef_idx = (coef_idx + 1 >= k*k) ? 0 : coef_idx + 1;
            return 1'b0;
        end
        if (r >= n) r = 0;
        if (c >= n) c = 0;
        rows_mem[r % MAXK][c] = v;
        if (r + 1 >= k && c + 1 >= k) begin
            for (int a = 0; a < k; a++) begin
                slot = (r + MAXK - a) % MAXK;
                for (int b = 0; b < k; b++)
                    acc += longint'(rows_mem[slot][c-b]) * longint'(coef_mem[a*k+b]);
            end
            res.sum = acc[c2d_pkg::SUM_W-1:0];
            res.row_end = (c + 1 == n);
            res.last = (c + 1 == n) && (r + 1 == n);
            due = 1'b1;
        end
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        pos_row = r;
        pos_col = c;
        return due;
    endfunction

    // result side: check each beat, random pop gaps
    int pop_gap = 0;
    always @(posedge i_clk) begin
        t_conv_out want;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                n_results++;
                if (pending_sums.size() == 0) begin
                    $error("result beat with nothing expected: sum %0d", o_conv_sum);
                    errors++;
                end else begin
                    want = pending_sums.pop_front();
                    if (o_conv_sum !== want.sum) begin
                        $error("conv_sum expected %0d got %0d", want.sum, o_conv_sum);
                        errors++;
                    end
                    if (o_row_end !== want.row_end) begin
                        $error("row_end expected %0d got %0d", want.row_end, o_row_end);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $error("last expected %0d got %0d", want.last, o_last);
                        errors++;
                    end
                end
                pop_gap = recv_idle ? $urandom_range(0, 12) : 0;
            end
            if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // send one item beat; fixed rows override the model's expectation
    task automatic send_item(input logic mode, input logic signed [c2d_pkg::DATA_W-1:0] v,
                             input bit fixed, input t_conv_out typed);
        t_conv_out res;
        int gap;
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_mode <= mode;
        i_value <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        n_items++;
        if (conv_advance(mode, v, res))
            pending_sums.push_back(fixed ? typed : res);
        else if (fixed) begin
            $error("table row expects a sum the model does not produce");
            errors++;
        end
    endtask

    // wait for the unit to drain, then write one register
    task automatic write_reg(input logic idx, input int unsigned val);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= c2d_pkg::APB_ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == c2d_pkg::REG_IMAGE_SIZE) img_reg = val[c2d_pkg::IMG_REG_W-1:0];
        else ker_reg = val[c2d_pkg::KER_REG_W-1:0];
        coef_idx = 0;
        pos_row = 0;
        pos_col = 0;
    endtask

    function automatic logic signed [c2d_pkg::DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            default: return c2d_pkg::DATA_W'($urandom);
        endcase
    endfunction

    // 2x2 image with 2x2 kernel: a unit corner tap, then full-scale extremes,
    // then a wrapping kernel load and a coefficient swapped mid-image
    t_row dir_rows[] = '{
        '{MODE_KERNEL, 16'sd1,      0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sd0,      0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sd0,      0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sd0,      0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sd5,      0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sd6,      0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sd7,      0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   1, '{-38'sd32768, 1, 1}},
        '{MODE_KERNEL, 16'sh8000,   0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sh8000,   0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sh8000,   0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sh8000,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   1, '{38'sd4294967296, 1, 1}},
        '{MODE_KERNEL, 16'sh7fff,   0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sh7fff,   0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sh7fff,   0, '{0, 0, 0}},
        '{MODE_KERNEL, 16'sh7fff,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   1, '{-38'sd4294836224, 1, 1}},
        '{MODE_KERNEL, 16'sd3,      0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sd1,      0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh7fff,   0, '{0, 0, 0}},
        '{MODE_KERNEL, -16'sd2,     0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sh8000,   0, '{0, 0, 0}},
        '{MODE_PIXEL,  16'sd4,      0, '{0, 0, 0}}
    };

    // random phases: image and kernel register values, out-of-range ones included
    int unsigned phase_img[] = '{0, 5, 6, 4, 16, 511, 7, 3, 256, 2};
    int unsigned phase_ker[] = '{7, 5, 3, 0, 6, 1, 4, 3, 2, 1};
    int unsigned phase_px[]  = '{6, 50, 72, 20, 80, 60, 49, 18, 8, 30};

    initial begin
        t_conv_out none;
        int unsigned k;
        none = '{default: '0};
        img_reg = c2d_pkg::IMAGE_SIZE_RST;
        ker_reg = c2d_pkg::KERNEL_SIZE_RST;
        coef_idx = 0;
        pos_row = 0;
        pos_col = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(c2d_pkg::REG_IMAGE_SIZE, 2);
        write_reg(c2d_pkg::REG_KERNEL_SIZE, 2);
        foreach (dir_rows[i])
            send_item(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].res);

        foreach (phase_img[p]) begin
            write_reg(c2d_pkg::REG_IMAGE_SIZE, phase_img[p]);
            write_reg(c2d_pkg::REG_KERNEL_SIZE, phase_ker[p]);
            k = side_k();
            // full kernel first, sometimes a few extra coefficients that wrap
            for (int j = 0; j < k*k + ($urandom_range(0, 3) == 0 ? 3 : 0); j++)
                send_item(MODE_KERNEL, rand_value(), 0, none);
            for (int j = 0; j < phase_px[p]; j++) begin
                if (j % 40 == 0) begin
                    send_idle = ($urandom_range(0, 3) != 0);
                    recv_idle = ($urandom_range(0, 3) != 0);
                end
                if ($urandom_range(0, 19) == 0)
                    send_item(MODE_KERNEL, rand_value(), 0, none);
                send_item(MODE_PIXEL, rand_value(), 0, none);
            end
        end

        push <= 1'b0;
        @(posedge i_clk);
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d item beats and %0d result beats over %0d size settings",
                 n_items, n_results, phase_img.size() + 1);
        $display("errors: %0d", errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
